// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: hdl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Types, constants and twiddle table for the radix-2 FFT block.
// ----------------------------------------------------------------------------
`default_nettype none
package r2fft_pkg;

    localparam int MAX_POINTS_DEF   = 64;
    localparam int TWIDDLE_BITS_DEF = 16;
    localparam int DATA_W           = 23;
    localparam int IN_W             = 16;
    localparam int LOG_W            = 3;
    localparam int IDX_W            = 6;
    localparam int TABLE_FRAC       = 23;

    localparam logic [0:0] REG_LOG2_POINTS  = 1'b0;
    localparam logic [0:0] REG_INVERSE_MODE = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD,
        ST_BFLY,
        ST_WR,
        ST_EMIT
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       load;       // write input sample
        logic       rd;         // read butterfly operands
        logic       mul;        // form twiddle products
        logic       wr;         // write butterfly results
        logic       emit_rd;    // read one bin
        logic       inverse;
        logic [5:0] addr_p;
        logic [5:0] addr_q;
        logic [5:0] tw_k;       // twiddle index in 64ths
    } dp_cmd_t;

    localparam logic [23:0] QUARTER_COS [17] = '{
        24'd8388608, 24'd8348215, 24'd8227423, 24'd8027397, 24'd7750063,
        24'd7398092, 24'd6974873, 24'd6484482, 24'd5931642, 24'd5321677,
        24'd4660461, 24'd3954362, 24'd3210181, 24'd2435084, 24'd1636536,
        24'd822227,  24'd0
    };

    // cos(2*pi*k/64) at frac fraction bits, returned 26 bits signed
    function automatic logic signed [25:0] cos64(input logic [5:0] k, input int frac);
        logic [4:0]          q;
        logic                neg;
        logic signed [25:0]  mag;
        logic signed [25:0]  rnd;
        q   = 5'd0;
        neg = 1'b0;
        if (k <= 6'd16) q = k[4:0];
        else if (k <= 6'd32) begin q = 5'(6'd32 - k); neg = 1'b1; end
        else if (k <= 6'd48) begin q = 5'(k - 6'd32); neg = 1'b1; end
        else q = 5'(7'd64 - {1'b0, k});
        mag = 26'(QUARTER_COS[q]);
        if (frac >= TABLE_FRAC) rnd = mag <<< (frac - TABLE_FRAC);
        else rnd = (mag + (26'sd1 <<< (TABLE_FRAC - frac - 1))) >>> (TABLE_FRAC - frac);
        return neg ? -rnd : rnd;
    endfunction

    function automatic logic [5:0] bitrev(input logic [5:0] v, input logic [2:0] l);
        logic [5:0] r;
        r = 6'd0;
        for (int b = 0; b < 6; b++)
            if (b < int'(l) && v[b]) r[int'(l) - 1 - b] = 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/r2fft_dp.sv
// ----------------------------------------------------------------------------
// r2fft_dp
// Datapath: sample memory, twiddle lookup, butterfly unit and output reg.
// ----------------------------------------------------------------------------
`default_nettype none
module r2fft_dp #(
    parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
    input  wire                                   clk,
    input  wire r2fft_pkg::dp_cmd_t               cmd,
    input  wire logic signed [r2fft_pkg::IN_W-1:0] in_re,
    input  wire logic signed [r2fft_pkg::IN_W-1:0] in_im,
    output logic signed [r2fft_pkg::DATA_W-1:0]   out_re,
    output logic signed [r2fft_pkg::DATA_W-1:0]   out_im
);
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int FRAC = TWIDDLE_BITS - 1;
    localparam int DW   = r2fft_pkg::DATA_W;
    localparam int PW   = DW + TWIDDLE_BITS + 2;

    logic signed [DW-1:0] mem_re [MAX_POINTS];
    logic signed [DW-1:0] mem_im [MAX_POINTS];

    logic signed [DW-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [TWIDDLE_BITS:0] wr_reg, wi_reg;
    logic signed [PW-1:0] tr_reg, ti_reg;
    logic signed [DW-1:0] sa_re, sa_im, ss_re, ss_im;
    logic signed [25:0]   wc, ws;
    logic signed [PW-1:0] pr, pi_;
    logic signed [PW-1:0] tr_rnd, ti_rnd;

    // twiddle lookup
    always_comb
    begin
        wc = r2fft_pkg::cos64(cmd.tw_k, FRAC);
        ws = r2fft_pkg::cos64(6'(cmd.tw_k + 6'd48), FRAC);
        if (!cmd.inverse) ws = -ws;
    end

    // memory and operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem_re[cmd.addr_p[AW-1:0]] <= DW'(in_re);
            mem_im[cmd.addr_p[AW-1:0]] <= DW'(in_im);
        end
        if (cmd.wr)
        begin
            mem_re[cmd.addr_p[AW-1:0]] <= sa_re;
            mem_im[cmd.addr_p[AW-1:0]] <= sa_im;
            mem_re[cmd.addr_q[AW-1:0]] <= ss_re;
            mem_im[cmd.addr_q[AW-1:0]] <= ss_im;
        end
        if (cmd.rd || cmd.emit_rd)
        begin
            ar_reg <= mem_re[cmd.addr_p[AW-1:0]];
            ai_reg <= mem_im[cmd.addr_p[AW-1:0]];
            br_reg <= mem_re[cmd.addr_q[AW-1:0]];
            bi_reg <= mem_im[cmd.addr_q[AW-1:0]];
            wr_reg <= (TWIDDLE_BITS+1)'(wc);
            wi_reg <= (TWIDDLE_BITS+1)'(ws);
        end
        if (cmd.mul)
        begin
            tr_reg <= tr_rnd;
            ti_reg <= ti_rnd;
        end
    end

    // complex product, rounded
    always_comb
    begin
        pr  = PW'(wr_reg) * PW'(br_reg) - PW'(wi_reg) * PW'(bi_reg);
        pi_ = PW'(wr_reg) * PW'(bi_reg) + PW'(wi_reg) * PW'(br_reg);
        tr_rnd = (pr + (PW'(1) <<< (FRAC - 1))) >>> FRAC;
        ti_rnd = (pi_ + (PW'(1) <<< (FRAC - 1))) >>> FRAC;
    end

    function automatic logic signed [DW-1:0] sat(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi, lo;
        hi = PW'((1 <<< (DW - 1)) - 1);
        lo = -PW'(1 <<< (DW - 1));
        if (v > hi) return hi[DW-1:0];
        if (v < lo) return lo[DW-1:0];
        return v[DW-1:0];
    endfunction

    // butterfly sums
    always_comb
    begin
        sa_re = sat(PW'(ar_reg) + tr_reg);
        sa_im = sat(PW'(ai_reg) + ti_reg);
        ss_re = sat(PW'(ar_reg) - tr_reg);
        ss_im = sat(PW'(ai_reg) - ti_reg);
    end

    assign out_re = ar_reg;
    assign out_im = ai_reg;
endmodule
`default_nettype wire

// File: hdl/r2fft_ctrl.sv
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Controller: frame loading, stage/butterfly sequencing and bin emission.
// ----------------------------------------------------------------------------
`default_nettype none
module r2fft_ctrl #(
    parameter int MAX_POINTS = r2fft_pkg::MAX_POINTS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    input  wire [2:0]              log2_cfg,
    input  wire                    inverse_cfg,
    input  wire                    clr_count,
    output logic                   busy,
    output r2fft_pkg::dp_cmd_t     cmd,
    output logic                   out_strobe,
    output logic [5:0]             out_index,
    output logic                   out_last
);
    // log2 of the largest power of two not above MAX_POINTS
    localparam int MAXL = $clog2(MAX_POINTS + 1) - 1;

    r2fft_pkg::state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;     // loaded count / butterfly index / bin
    logic [2:0] stage_reg, stage_next;
    logic [2:0] l_reg, l_next;
    logic       inv_reg, inv_next;
    logic       emit_v_reg, emit_v_next;
    logic [5:0] emit_i_reg, emit_i_next;
    logic [2:0] leff;
    logic [6:0] n, halfn;
    logic [5:0] half, jj, base, p;

    assign leff  = (int'(log2_cfg) > MAXL) ? 3'(MAXL) : log2_cfg;
    assign n     = 7'd1 << l_reg;
    assign halfn = n >> 1;
    assign half  = 6'(7'd1 << stage_reg);
    assign jj    = cnt_reg[5:0] & 6'(half - 6'd1);
    assign base  = 6'((cnt_reg[5:0] - jj) << 1);
    assign p     = base | jj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= r2fft_pkg::ST_LOAD;
            cnt_reg    <= 7'd0;
            stage_reg  <= 3'd0;
            l_reg      <= 3'd0;
            inv_reg    <= 1'b0;
            emit_v_reg <= 1'b0;
            emit_i_reg <= 6'd0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            stage_reg  <= stage_next;
            l_reg      <= l_next;
            inv_reg    <= inv_next;
            emit_v_reg <= emit_v_next;
            emit_i_reg <= emit_i_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        stage_next  = stage_reg;
        l_next      = l_reg;
        inv_next    = inv_reg;
        emit_v_next = 1'b0;
        emit_i_next = emit_i_reg;
        cmd         = '0;
        cmd.inverse = inv_reg;
        busy        = 1'b1;
        unique case (state_reg)
            r2fft_pkg::ST_LOAD:
            begin
                busy = 1'b0;
                // store bit-reversed so stages run in place
                cmd.addr_p = r2fft_pkg::bitrev(cnt_reg[5:0], leff);
                if (clr_count) cnt_next = 7'd0;
                else if (start)
                begin
                    cmd.load = 1'b1;
                    if (cnt_reg + 7'd1 >= (7'd1 << leff))
                    begin
                        cnt_next   = 7'd0;
                        stage_next = 3'd0;
                        l_next     = leff;
                        inv_next   = inverse_cfg;
                        state_next = (leff == 3'd0) ? r2fft_pkg::ST_EMIT
                                                    : r2fft_pkg::ST_RD;
                    end
                    else cnt_next = cnt_reg + 7'd1;
                end
            end
            r2fft_pkg::ST_RD:
            begin
                cmd.rd     = 1'b1;
                cmd.addr_p = p;
                cmd.addr_q = p + half;
                cmd.tw_k   = 6'(jj << (3'd5 - stage_reg));
                state_next = r2fft_pkg::ST_BFLY;
            end
            r2fft_pkg::ST_BFLY:
            begin
                cmd.mul    = 1'b1;
                state_next = r2fft_pkg::ST_WR;
            end
            r2fft_pkg::ST_WR:
            begin
                cmd.wr     = 1'b1;
                cmd.addr_p = p;
                cmd.addr_q = p + half;
                state_next = r2fft_pkg::ST_RD;
                if (cnt_reg + 7'd1 >= halfn)
                begin
                    cnt_next = 7'd0;
                    if (stage_reg + 3'd1 >= l_reg) state_next = r2fft_pkg::ST_EMIT;
                    else stage_next = stage_reg + 3'd1;
                end
                else cnt_next = cnt_reg + 7'd1;
            end
            r2fft_pkg::ST_EMIT:
            begin
                cmd.emit_rd = 1'b1;
                cmd.addr_p  = cnt_reg[5:0];
                emit_v_next = 1'b1;
                emit_i_next = cnt_reg[5:0];
                if (cnt_reg + 7'd1 >= n)
                begin
                    cnt_next   = 7'd0;
                    state_next = r2fft_pkg::ST_LOAD;
                end
                else cnt_next = cnt_reg + 7'd1;
            end
            default: state_next = r2fft_pkg::ST_LOAD;
        endcase
    end

    assign out_strobe = emit_v_reg;
    assign out_index  = emit_i_reg;
    assign out_last   = emit_v_reg && ({1'b0, emit_i_reg} == n - 7'd1);
endmodule
`default_nettype wire

// File: hdl/radix2_fft_1d.sv
// ----------------------------------------------------------------------------
// radix2_fft_1d
// Radix-2 DIT FFT/IFFT, unscaled, frames of 2^log2_points complex samples.
// ----------------------------------------------------------------------------
// channel   signals                                   handshake
// input     start, sample_real, sample_imag           start & !busy
// result    strobe, bin_real, bin_imag, bin_index,    strobe, one cycle
//           last_bin
// config    cfg_valid, cfg_ready, cfg_index, cfg_data valid & ready
//
// Samples load one per cycle while busy is low. After the N-th sample the
// block is busy through (N/2)*log2N butterflies (one shared butterfly unit
// on a memory read/write sequence of read, multiply and write states) and
// then while it emits the N bins; bins follow one per cycle. Results cannot
// be stalled. Reset clears the load count and sets log2_points to 6,
// inverse_mode to 0. Writing log2_points drops a partial frame.
`default_nettype none
`include "assert_macros.svh"
module radix2_fft_1d #(
    parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  wire logic signed [15:0] sample_real,
    input  wire logic signed [15:0] sample_imag,
    output logic              strobe,
    output logic signed [22:0] bin_real,
    output logic signed [22:0] bin_imag,
    output logic [5:0]        bin_index,
    output logic              last_bin,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire [0:0]         cfg_index,
    input  wire [2:0]         cfg_data
);
    logic [2:0] log2_reg;
    logic       inv_reg;
    logic       cfg_wr;
    r2fft_pkg::dp_cmd_t cmd;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg <= 3'd6;
            inv_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                r2fft_pkg::REG_LOG2_POINTS:  log2_reg <= cfg_data;
                r2fft_pkg::REG_INVERSE_MODE: inv_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    r2fft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start),
        .log2_cfg(log2_reg), .inverse_cfg(inv_reg),
        .clr_count(cfg_wr && cfg_index == r2fft_pkg::REG_LOG2_POINTS),
        .busy(busy), .cmd(cmd),
        .out_strobe(strobe), .out_index(bin_index), .out_last(last_bin)
    );

    r2fft_dp #(.MAX_POINTS(MAX_POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_dp (
        .clk(clk), .cmd(cmd), .in_re(sample_real), .in_im(sample_imag),
        .out_re(bin_real), .out_im(bin_imag)
    );

    `ASSERT_IMPLIES(a_last_strobe, clk, rst_n, last_bin, strobe)
    `ASSERT_IMPLIES(a_busy_strobe, clk, rst_n, strobe && !last_bin, busy)
    `ASSERT_NEXT(a_last_idle, clk, rst_n, last_bin, !strobe)
endmodule
`default_nettype wire
